### rtl/n4dq_pkg.sv
`default_nettype none
package n4dq_pkg;

  typedef struct packed {
    logic [15:0] scale;
    logic [7:0]  packed_byte;
    logic [3:0]  byte_position;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] low_weight;
    logic [4:0]  low_index;
    logic [15:0] high_weight;
    logic [4:0]  high_index;
  } out_beat_t;

  localparam logic [0:0] RegCodebookLow  = 1'b0;
  localparam logic [0:0] RegCodebookHigh = 1'b1;

  localparam logic [15:0] QuietNan = 16'h7e00;
  localparam logic [15:0] QuietBit = 16'h0200;
  localparam logic [14:0] InfMag   = 15'h7c00;

  // stage 1 to stage 2 bundle of one lane
  typedef struct packed {
    logic        special;
    logic [15:0] special_val;
    logic        sign;
    logic [17:0] prod;
    logic [5:0]  ex_b;     // exponent offset ex + 25 (1..31)
  } mul_st_t;

  // stage 2 to stage 3 bundle of one lane
  typedef struct packed {
    logic        special;
    logic [15:0] special_val;
    logic        sign;
    logic        zero;
    logic [17:0] prod;
    logic [6:0]  tgt;      // 1..38
    logic [5:0]  rsh;      // right shift amount (0 if left)
    logic [5:0]  lsh;      // left shift amount
  } nrm_st_t;

endpackage
`default_nettype wire

### rtl/n4dq_lane.sv
`default_nettype none
module n4dq_lane (
  input  wire              clk,
  input  wire [15:0]       scale,
  input  wire signed [7:0] code,
  input  wire              adv1,
  input  wire              adv2,
  input  wire              adv3,
  output logic [15:0]      weight
);
  import n4dq_pkg::*;

  // stage 1: unpack, special cases, multiply
  logic        s_sign;
  logic [4:0]  s_exp;
  logic [9:0]  s_man;
  logic [7:0]  k_abs;
  logic [10:0] sig;
  mul_st_t     m_d, m_q;

  always_comb begin
    s_sign = scale[15];
    s_exp  = scale[14:10];
    s_man  = scale[9:0];
    k_abs  = code[7] ? 8'(-code) : 8'(code);
    sig    = (s_exp == 5'd0) ? {1'b0, s_man} : {1'b1, s_man};
    m_d.sign = s_sign ^ code[7];
    m_d.prod = 18'(sig) * 18'(k_abs);
    m_d.ex_b = (s_exp == 5'd0) ? 6'd1 : {1'b0, s_exp};
    m_d.special = (s_exp == 5'h1f);
    if (s_man != 10'd0)
      m_d.special_val = scale | QuietBit;
    else if (k_abs == 8'd0)
      m_d.special_val = QuietNan;
    else
      m_d.special_val = {m_d.sign, InfMag};
  end

  always_ff @(posedge clk) begin
    if (adv1) m_q <= m_d;
  end

  // stage 2: leading one and shift amount
  logic [4:0] n;
  logic [6:0] be;
  logic [6:0] tgt;
  logic [6:0] sh;
  nrm_st_t    r_d, r_q;

  always_comb begin
    n = 5'd0;
    for (int i = 0; i < 18; i++) begin
      if (m_q.prod[i]) n = 5'(i);
    end
    // be = n + ex + 15 = n + ex_b - 10
    be  = 7'(n) + 7'(m_q.ex_b) - 7'd10;
    tgt = (be[6] || be == 7'd0) ? 7'd1 : be;
    // sh = tgt - 25 - ex = tgt - ex_b
    sh  = tgt - 7'(m_q.ex_b);
    r_d.special     = m_q.special;
    r_d.special_val = m_q.special_val;
    r_d.sign        = m_q.sign;
    r_d.zero        = (m_q.prod == 18'd0);
    r_d.prod        = m_q.prod;
    r_d.tgt         = tgt;
    r_d.rsh         = sh[6] ? 6'd0 : 6'(sh);
    r_d.lsh         = sh[6] ? 6'(-sh) : 6'd0;
  end

  always_ff @(posedge clk) begin
    if (adv2) r_q <= r_d;
  end

  // stage 3: shift, round, pack
  logic [17:0] q;
  logic [17:0] rem;
  logic [17:0] half;
  logic [17:0] mask;
  logic [17:0] tot;
  logic [15:0] w_d;

  always_comb begin
    mask = (18'd1 << r_q.rsh) - 18'd1;
    rem  = r_q.prod & mask;
    half = (r_q.rsh == 6'd0) ? 18'd0 : (18'd1 << (r_q.rsh - 6'd1));
    if (r_q.rsh != 6'd0) begin
      q = r_q.prod >> r_q.rsh;
      if (rem > half || (rem == half && q[0])) q = q + 18'd1;
    end else begin
      q = r_q.prod << r_q.lsh;
    end
    tot = {r_q.tgt[6:0] - 7'd1, 10'd0} + q;
    if (r_q.special)
      w_d = r_q.special_val;
    else if (r_q.zero)
      w_d = {r_q.sign, 15'd0};
    else if (tot >= 18'h7c00)
      w_d = {r_q.sign, InfMag};
    else
      w_d = {r_q.sign, tot[14:0]};
  end

  always_ff @(posedge clk) begin
    if (adv3) weight <= w_d;
  end
endmodule
`default_nettype wire

### rtl/nonlinear_4bit_dequantizer_unit.sv
`default_nettype none
// Dequantizes one packed byte of 4-bit codebook indices per clock. A beat is
// taken whenever start is high (busy is always low), and both fp16 weights
// come out on the result ports with done high for exactly one cycle; the
// receiver cannot stall, so results are never held back. Each lane has three
// pipeline stages: multiply, leading one search, and shift/round/pack.
// Throughput is one beat per cycle. The codebook lives in two 64-bit
// registers at byte addresses 0 and 8 and must only be rewritten while no
// beat is in flight.
module nonlinear_4bit_dequantizer_unit (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  output logic                  busy,
  input  wire n4dq_pkg::in_beat_t  in_beat,
  output logic                  done,
  output n4dq_pkg::out_beat_t   out_beat,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire [3:0]             paddr,
  input  wire [63:0]            pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);
  import n4dq_pkg::*;

  logic [63:0] codebook_low;
  logic [63:0] codebook_high;
  logic        reg_sel;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign reg_sel = paddr[3];

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      codebook_low  <= 64'd0;
      codebook_high <= 64'd0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2:0] == 3'd0 && reg_sel == RegCodebookLow) codebook_low <= pwdata;
      if (paddr[2:0] == 3'd0 && reg_sel == RegCodebookHigh) codebook_high <= pwdata;
    end
  end

  always_comb begin
    prdata = 64'd0;
    if (paddr[2:0] == 3'd0) prdata = (reg_sel == RegCodebookHigh) ? codebook_high : codebook_low;
  end

  // codebook lookup at entry
  logic [3:0]        lo_idx, hi_idx;
  logic [63:0]       lo_word, hi_word;
  logic signed [7:0] lo_code, hi_code;

  always_comb begin
    lo_idx  = in_beat.packed_byte[3:0];
    hi_idx  = in_beat.packed_byte[7:4];
    lo_word = lo_idx[3] ? codebook_high : codebook_low;
    hi_word = hi_idx[3] ? codebook_high : codebook_low;
    lo_code = lo_word[{lo_idx[2:0], 3'd0} +: 8];
    hi_code = hi_word[{hi_idx[2:0], 3'd0} +: 8];
  end

  // valid and position travel alongside the lanes
  logic [2:0] vld;
  logic [3:0] pos1, pos2, pos3;

  always_ff @(posedge clk) begin
    if (rst) vld <= 3'd0;
    else     vld <= {vld[1:0], start};
  end

  always_ff @(posedge clk) begin
    if (start)  pos1 <= in_beat.byte_position;
    if (vld[0]) pos2 <= pos1;
    if (vld[1]) pos3 <= pos2;
  end

  logic [15:0] lo_w, hi_w;

  n4dq_lane u_lo (
    .clk(clk), .scale(in_beat.scale), .code(lo_code),
    .adv1(start), .adv2(vld[0]), .adv3(vld[1]), .weight(lo_w)
  );

  n4dq_lane u_hi (
    .clk(clk), .scale(in_beat.scale), .code(hi_code),
    .adv1(start), .adv2(vld[0]), .adv3(vld[1]), .weight(hi_w)
  );

  // result beat: low weight, low index, high weight, high index
  assign done     = vld[2];
  assign out_beat = {lo_w, 1'b0, pos3, hi_w, 1'b1, pos3};
endmodule
`default_nettype wire

### rtl/n4dq_checker.sv
`default_nettype none
module n4dq_checker (
  input wire                      clk,
  input wire                      rst,
  input wire                      start,
  input wire                      busy,
  input wire                      done,
  input wire n4dq_pkg::out_beat_t out_beat,
  input wire                      pready
);
  import n4dq_pkg::*;

  a_lat: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> ##2 done) else $error("result missing");

  a_idx: assert property (@(posedge clk) disable iff (rst)
    done |-> out_beat.high_index == {1'b1, out_beat.low_index[3:0]})
    else $error("index mismatch");

  a_idle: assert property (@(posedge clk) disable iff (rst)
    !start ##1 !start ##1 !start |=> !done) else $error("spurious result");

  a_rdy: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind nonlinear_4bit_dequantizer_unit n4dq_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .out_beat(out_beat), .pready(pready)
);
`default_nettype wire
